### design/rtpl_pkg.sv
// Package for the route table prefix lookup block.
// Holds the table size, request and status codes, the table entry layout,
// the controller/datapath command and status structs and a popcount helper.
package rtpl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

  localparam int FLAG_UP_BIT = 0;
  localparam int FLAG_GW_BIT = 1;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DEL    = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_POS  = 2'd2,
    ST_NO_ROUTE = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [2:0]  flags;
    logic [3:0]  port;
    logic [7:0]  metric;
    logic [5:0]  len;
  } entry_t;

  typedef struct packed {
    logic    load_req;
    logic    add_write;
    logic    dec_count;
    logic    del_start;
    logic    shift_step;
    logic    scan_start;
    logic    scan_step;
    logic    set_status;
    status_t status_code;
    logic    lk_result;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic pos_bad;
    logic del_last;
    logic shift_last;
    logic scan_last;
    logic cnt_zero;
  } stat_t;

  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[5:0];
  endfunction

endpackage

### design/rtpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module rtpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rtpl_datapath.sv
// Datapath of the route table: request registers, route count, table RAM,
// scan index, best-match tracking and result registers.
// Depends on rtpl_pkg and rtpl_ram.
module rtpl_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rtpl_pkg::cmd_t        cmd,
  output rtpl_pkg::stat_t       stat,
  input  logic [1:0]            in_req_type,
  input  logic [31:0]           in_dest_ip,
  input  logic [31:0]           in_net_mask,
  input  logic [31:0]           in_gateway_ip,
  input  logic [2:0]            in_route_flags,
  input  logic [3:0]            in_out_port,
  input  logic [7:0]            in_route_metric,
  input  logic [3:0]            in_position,
  output logic [1:0]            out_status,
  output logic [31:0]           out_next_hop,
  output logic [3:0]            out_hit_port,
  output logic [7:0]            out_hit_metric,
  output logic [4:0]            out_route_count
);
  import rtpl_pkg::*;

  req_t        req_r;
  logic [31:0] dst_r;
  logic [31:0] mask_r;
  logic [31:0] gw_r;
  logic [2:0]  flags_r;
  logic [3:0]  port_r;
  logic [7:0]  metric_r;
  logic [3:0]  pos_r;

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  logic [5:0]       best_len_r;
  logic [31:0]      best_gw_r;
  logic             best_use_gw_r;
  logic [3:0]       best_port_r;
  logic [7:0]       best_metric_r;

  status_t     res_status_r;
  logic [31:0] res_hop_r;
  logic [3:0]  res_port_r;
  logic [7:0]  res_metric_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             hit;
  logic             better;
  entry_t           new_entry;

  rtpl_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_ext = CMP_W'(pos_r);
  assign idx_ext = CMP_W'(idx_r);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    new_entry.dest    = dst_r;
    new_entry.mask    = mask_r;
    new_entry.gateway = gw_r;
    new_entry.flags   = flags_r;
    new_entry.port    = port_r;
    new_entry.metric  = metric_r;
    new_entry.len     = popcount32(mask_r);
  end

  always_comb begin
    ram_we    = cmd.add_write | cmd.shift_step;
    ram_waddr = cmd.shift_step ? idx_r : IDX_W'(count_r);
    ram_wdata = cmd.shift_step ? ram_rdata : new_entry;
    if (cmd.del_start) begin
      ram_raddr = IDX_W'(pos_ext + CMP_W'(1));
    end else if (cmd.shift_step) begin
      ram_raddr = IDX_W'(idx_ext + CMP_W'(2));
    end else if (cmd.scan_step) begin
      ram_raddr = IDX_W'(idx_ext + CMP_W'(1));
    end else begin
      ram_raddr = '0;
    end
  end

  assign hit    = ram_rdata.flags[FLAG_UP_BIT] && ((dst_r & ram_rdata.mask) == ram_rdata.dest);
  assign better = !found_r || (ram_rdata.len > best_len_r);

  always_comb begin
    stat.req        = req_r;
    stat.full       = (count_r >= CNT_W'(TABLE_DEPTH));
    stat.pos_bad    = (pos_ext >= cnt_ext);
    stat.del_last   = ((pos_ext + CMP_W'(1)) >= cnt_ext);
    stat.shift_last = ((idx_ext + CMP_W'(2)) >= cnt_ext);
    stat.scan_last  = ((idx_ext + CMP_W'(1)) >= cnt_ext);
    stat.cnt_zero   = (count_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.add_write) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.dec_count) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r    <= req_t'(in_req_type);
      dst_r    <= in_dest_ip;
      mask_r   <= in_net_mask;
      gw_r     <= in_gateway_ip;
      flags_r  <= in_route_flags;
      port_r   <= in_out_port;
      metric_r <= in_route_metric;
      pos_r    <= in_position;
    end

    if (cmd.del_start) begin
      idx_r <= IDX_W'(pos_r);
    end else if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.shift_step || cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
    end

    if (cmd.scan_start) begin
      found_r <= 1'b0;
    end else if (cmd.scan_step && hit && better) begin
      found_r       <= 1'b1;
      best_len_r    <= ram_rdata.len;
      best_gw_r     <= ram_rdata.gateway;
      best_use_gw_r <= ram_rdata.flags[FLAG_GW_BIT];
      best_port_r   <= ram_rdata.port;
      best_metric_r <= ram_rdata.metric;
    end

    if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
      res_hop_r    <= '0;
      res_port_r   <= '0;
      res_metric_r <= '0;
    end else if (cmd.lk_result) begin
      if (found_r) begin
        res_status_r <= ST_OK;
        res_hop_r    <= best_use_gw_r ? best_gw_r : dst_r;
        res_port_r   <= best_port_r;
        res_metric_r <= best_metric_r;
      end else begin
        res_status_r <= ST_NO_ROUTE;
        res_hop_r    <= '0;
        res_port_r   <= '0;
        res_metric_r <= '0;
      end
    end
  end

  assign out_status      = res_status_r;
  assign out_next_hop    = res_hop_r;
  assign out_hit_port    = res_port_r;
  assign out_hit_metric  = res_metric_r;
  assign out_route_count = 5'(count_r);

endmodule

### design/rtpl_ctrl.sv
// Controller state machine of the route table.
// Sequences add, delete-compaction and lookup scans. Depends on rtpl_pkg.
module rtpl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  input  rtpl_pkg::stat_t stat,
  output rtpl_pkg::cmd_t  cmd
);
  import rtpl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_LKEND  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy      = !((state_r == S_IDLE) || (state_r == S_DONE));
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.status_code = ST_OK;
    unique case (state_r) inside
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DECODE: begin
        state_nxt      = S_DONE;
        cmd.set_status = 1'b1;
        unique case (stat.req)
          REQ_ADD: begin
            if (stat.full) begin
              cmd.status_code = ST_FULL;
            end else begin
              cmd.add_write = 1'b1;
            end
          end
          REQ_DEL: begin
            if (stat.pos_bad) begin
              cmd.status_code = ST_BAD_POS;
            end else if (stat.del_last) begin
              cmd.dec_count = 1'b1;
            end else begin
              cmd.set_status = 1'b0;
              cmd.del_start  = 1'b1;
              state_nxt      = S_SHIFT;
            end
          end
          REQ_LOOKUP: begin
            if (stat.cnt_zero) begin
              cmd.status_code = ST_NO_ROUTE;
            end else begin
              cmd.set_status = 1'b0;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            cmd.status_code = ST_OK;
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          cmd.dec_count  = 1'b1;
          cmd.set_status = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_LKEND;
        end
      end
      S_LKEND: begin
        cmd.lk_result = 1'b1;
        state_nxt     = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/route_table_prefix_lookup.sv
// Top level of the route table prefix lookup block.
// Add, unknown requests, errors, a lookup in an empty table and deleting the last route go
// from decode straight to done. Other deletes move each route after the deleted one into
// the slot before it; other lookups scan every route, then pass a result state to done.
// One table RAM access per cycle sets the scan rate. A new item is taken in the strobe cycle
// when not busy; the receiver cannot stall results. Reset empties the table; no clearing pass.
module route_table_prefix_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_dest_ip,
  input  logic [31:0] in_net_mask,
  input  logic [31:0] in_gateway_ip,
  input  logic [2:0]  in_route_flags,
  input  logic [3:0]  in_out_port,
  input  logic [7:0]  in_route_metric,
  input  logic [3:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_next_hop,
  output logic [3:0]  out_hit_port,
  output logic [7:0]  out_hit_metric,
  output logic [4:0]  out_route_count
);
  import rtpl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rtpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtpl_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_dest_ip     (in_dest_ip),
    .in_net_mask    (in_net_mask),
    .in_gateway_ip  (in_gateway_ip),
    .in_route_flags (in_route_flags),
    .in_out_port    (in_out_port),
    .in_route_metric(in_route_metric),
    .in_position    (in_position),
    .out_status     (out_status),
    .out_next_hop   (out_next_hop),
    .out_hit_port   (out_hit_port),
    .out_hit_metric (out_hit_metric),
    .out_route_count(out_route_count)
  );

endmodule
